[hw/rtl/clni_pkg.sv]
// Package: shared types, constants and the power-up table of the character LCD interface.
`default_nettype none

package clni_pkg;

    localparam int LINE_LENGTH = 16;

    localparam logic [5:0] LINE_LEN = 6'(LINE_LENGTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CMD_FUNCSET  = 8'h28;
    localparam logic [7:0] CMD_DISPON   = 8'h0E;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] DDRAM_BASE   = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
    localparam logic [3:0] MODE4_NIBBLE = 4'h2;

    localparam logic [1:0] WAIT_SHORT = 2'd0;
    localparam logic [1:0] WAIT_CLEAR = 2'd1;
    localparam logic [1:0] WAIT_POWER = 2'd2;

    localparam logic [1:0] ROW_ONE = 2'd1;
    localparam logic [1:0] ROW_TWO = 2'd2;

    localparam logic [3:0] INIT_LAST_STEP = 4'd11;

    typedef enum logic [1:0] {
        ACT_PRINT   = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_CURSOR  = 2'd2,
        ACT_INIT    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        JOB_PRINT   = 2'd0,
        JOB_COMMAND = 2'd1,
        JOB_REJECT  = 2'd2,
        JOB_INIT    = 2'd3
    } job_kind_t;

    // One classified request: what the back end has to emit
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] low_wait;
        logic [3:0] last_step;
        logic [1:0] row;
        logic [5:0] column;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_head_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic [1:0] wait_code;
    } init_item_t;

    function automatic init_item_t init_item(input logic [3:0] step);
        init_item_t it;
        it.wait_code = WAIT_SHORT;
        it.nibble    = 4'h0;
        case (step)
            4'd0:  begin it.nibble = WAKE_NIBBLE;        it.wait_code = WAIT_POWER; end
            4'd1:  it.nibble = WAKE_NIBBLE;
            4'd2:  it.nibble = WAKE_NIBBLE;
            4'd3:  it.nibble = MODE4_NIBBLE;
            4'd4:  it.nibble = CMD_FUNCSET[7:4];
            4'd5:  begin it.nibble = CMD_FUNCSET[3:0]; it.wait_code = WAIT_POWER; end
            4'd6:  it.nibble = CMD_DISPON[7:4];
            4'd7:  begin it.nibble = CMD_DISPON[3:0];  it.wait_code = WAIT_POWER; end
            4'd8:  it.nibble = CMD_CLEAR[7:4];
            4'd9:  begin it.nibble = CMD_CLEAR[3:0];   it.wait_code = WAIT_CLEAR; end
            4'd10: it.nibble = CMD_ENTRY[7:4];
            4'd11: begin it.nibble = CMD_ENTRY[3:0];   it.wait_code = WAIT_POWER; end
            default: it.nibble = 4'h0;
        endcase
        return it;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/clni_req_if.sv]
// Interface: request channel of the character LCD interface.
`default_nettype none

interface clni_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [1:0] target_row;
    logic [5:0] target_column;

    modport source (
        output valid, action, data_byte, target_row, target_column,
        input  ready
    );

    modport sink (
        input  valid, action, data_byte, target_row, target_column,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/clni_res_if.sv]
// Interface: nibble transfer result channel of the character LCD interface.
`default_nettype none

interface clni_res_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [3:0] nibble;
    logic [1:0] wait_code;
    logic       rejected;
    logic       last;
    logic [1:0] cursor_row;
    logic [5:0] cursor_column;

    modport source (
        output valid, register_select, nibble, wait_code, rejected, last,
               cursor_row, cursor_column,
        input  ready
    );

    modport sink (
        input  valid, register_select, nibble, wait_code, rejected, last,
               cursor_row, cursor_column,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/clni_front.sv]
// Front end: accepts requests, tracks the cursor and classifies each request into a job.
`default_nettype none

module clni_front (
    input  logic                clk,
    input  logic                rst_n,
    clni_req_if.sink            req,
    input  logic                q_full,
    output clni_pkg::job_push_t push
);
    import clni_pkg::*;

    logic [1:0] row_reg, row_next;
    logic [5:0] column_reg, column_next;
    logic [5:0] column_inc;
    logic [5:0] col_less;
    logic       accept;
    logic       cursor_ok;
    job_t       job;

    assign req.ready  = !q_full;
    assign accept     = req.valid && req.ready;
    assign column_inc = column_reg + 6'd1;
    assign col_less   = req.target_column - 6'd1;
    assign cursor_ok  = (req.target_row == ROW_ONE || req.target_row == ROW_TWO)
                        && (req.target_column != 6'd0)
                        && (req.target_column <= LINE_LEN);

    always_comb
    begin
        row_next      = row_reg;
        column_next   = column_reg;
        job.kind      = JOB_REJECT;
        job.byte0     = req.data_byte;
        job.byte1     = DDRAM_BASE;
        job.low_wait  = WAIT_SHORT;
        job.last_step = 4'd0;
        case (action_t'(req.action))
            ACT_PRINT:
            begin
                job.kind = JOB_PRINT;
                if (column_inc > LINE_LEN)
                begin
                    // wrap to the start of the other line and readdress DDRAM
                    column_next   = 6'd1;
                    row_next      = (row_reg == ROW_ONE) ? ROW_TWO : ROW_ONE;
                    job.byte1     = (row_next == ROW_TWO) ? (DDRAM_BASE | LINE2_OFFSET)
                                                          : DDRAM_BASE;
                    job.last_step = 4'd3;
                end
                else
                begin
                    column_next   = column_inc;
                    job.last_step = 4'd1;
                end
            end
            ACT_COMMAND:
            begin
                job.kind      = JOB_COMMAND;
                job.last_step = 4'd1;
                if (req.data_byte == CMD_CLEAR || req.data_byte == CMD_HOME)
                begin
                    job.low_wait = WAIT_CLEAR;
                    row_next     = ROW_ONE;
                    column_next  = 6'd1;
                end
            end
            ACT_CURSOR:
            begin
                if (cursor_ok)
                begin
                    job.kind      = JOB_COMMAND;
                    job.last_step = 4'd1;
                    job.byte0     = ((req.target_row == ROW_TWO) ? (DDRAM_BASE | LINE2_OFFSET)
                                                                 : DDRAM_BASE)
                                    | {2'b00, col_less};
                    row_next      = req.target_row;
                    column_next   = req.target_column;
                end
            end
            ACT_INIT:
            begin
                job.kind      = JOB_INIT;
                job.last_step = INIT_LAST_STEP;
                row_next      = ROW_ONE;
                column_next   = 6'd1;
            end
            default:
            begin
                job.kind = JOB_REJECT;
            end
        endcase
        job.row    = row_next;
        job.column = column_next;
    end

    assign push.valid = accept;
    assign push.job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= ROW_ONE;
            column_reg <= 6'd1;
        end
        else if (accept)
        begin
            row_reg    <= row_next;
            column_reg <= column_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/clni_queue.sv]
// Job queue: short FIFO between the front end and the transfer sequencer.
`default_nettype none

module clni_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  clni_pkg::job_push_t push,
    output logic                full,
    output clni_pkg::job_head_t head,
    input  logic                pop
);
    import clni_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/clni_back.sv]
// Back end: steps through each job and issues one registered nibble transfer per cycle while the result sink is ready.
`default_nettype none

module clni_back (
    input  logic                clk,
    input  logic                rst_n,
    input  clni_pkg::job_head_t head,
    output logic                pop,
    clni_res_if.source          res
);
    import clni_pkg::*;

    logic [3:0] step_reg, step_next;
    logic       valid_reg;
    logic       rs_reg, rs_next;
    logic [3:0] nibble_reg, nibble_next;
    logic [1:0] wait_reg, wait_next;
    logic       rejected_reg, rejected_next;
    logic       last_reg;
    logic [1:0] row_reg;
    logic [5:0] column_reg;
    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;
    init_item_t init_it;

    assign load    = head.valid && (!valid_reg || res.ready);
    assign is_last = (step_reg == head.job.last_step);
    assign pop     = load && is_last;
    assign init_it = init_item(step_reg);

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = is_last ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_comb
    begin
        rs_next       = 1'b0;
        nibble_next   = 4'h0;
        wait_next     = WAIT_SHORT;
        rejected_next = 1'b0;
        sel_byte      = head.job.byte0;
        case (head.job.kind)
            JOB_PRINT:
            begin
                // character first, then the DDRAM address command after a wrap
                sel_byte    = step_reg[1] ? head.job.byte1 : head.job.byte0;
                rs_next     = !step_reg[1];
                nibble_next = step_reg[0] ? sel_byte[3:0] : sel_byte[7:4];
            end
            JOB_COMMAND:
            begin
                nibble_next = step_reg[0] ? sel_byte[3:0] : sel_byte[7:4];
                wait_next   = step_reg[0] ? head.job.low_wait : WAIT_SHORT;
            end
            JOB_REJECT:
            begin
                rejected_next = 1'b1;
            end
            JOB_INIT:
            begin
                nibble_next = init_it.nibble;
                wait_next   = init_it.wait_code;
            end
            default:
            begin
                rejected_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg       <= rs_next;
            nibble_reg   <= nibble_next;
            wait_reg     <= wait_next;
            rejected_reg <= rejected_next;
            last_reg     <= is_last;
            row_reg      <= head.job.row;
            column_reg   <= head.job.column;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= 4'd0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid           = valid_reg;
    assign res.register_select = rs_reg;
    assign res.nibble          = nibble_reg;
    assign res.wait_code       = wait_reg;
    assign res.rejected        = rejected_reg;
    assign res.last            = last_reg;
    assign res.cursor_row      = row_reg;
    assign res.cursor_column   = column_reg;

endmodule

`default_nettype wire

[hw/rtl/char_lcd_nibble_interface_top.sv]
// Two-line character LCD front end in 4-bit mode. Each request (print a character, send a
// command, set the cursor, run the power-up sequence) is classified in the cycle it is
// accepted and the cursor is updated there; the job then waits in a two-entry queue until
// the sequencer turns it into nibble transfers, high nibble first, one transfer per clock
// cycle while the result sink is ready, through a registered output. A request yields 1
// transfer (refused cursor), 2 (command, cursor, plain print), 4 (print that wraps the line)
// or 12 (power-up). Requests are taken one per cycle while the queue has room, so the
// sustained rate is set by the sequencer's output. Every transfer carries the
// cursor position as it stands after its request; each request's final transfer has last set.
`default_nettype none

module char_lcd_nibble_interface_top (
    input  logic       clk,
    input  logic       rst_n,
    clni_req_if.sink   req,
    clni_res_if.source res
);
    import clni_pkg::*;

    job_push_t push;
    job_head_t head;
    logic      q_full;
    logic      pop;

    clni_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (push)
    );

    clni_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    clni_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

`ifndef SYNTHESIS
    // a refused request is a single transfer with nothing on the bus
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.rejected |-> res.last && !res.register_select
                                      && res.nibble == 4'h0 && res.wait_code == WAIT_SHORT)
        else $error("rejected transfer is not a lone empty item");

    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.cursor_row == ROW_ONE || res.cursor_row == ROW_TWO))
        else $error("tracked cursor row out of range");

    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.cursor_column != 6'd0 && res.cursor_column <= LINE_LEN))
        else $error("tracked cursor column out of range");

    // the queue never takes a job it has no room for
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
        else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire
